@@ sv/fss_pkg.sv @@
// Package for the fuzzy subsequence scorer: widths, score constants,
// register codes, state types and byte class helpers. No dependencies.
package fss_pkg;

    localparam int QUERY_MAX = 32;
    localparam int QLEN_W    = 6;
    localparam int QIDX_W    = 5;
    localparam int TEXT_MAX  = 65536;
    localparam int POS_W     = 16;
    localparam int BPOS_W    = 17;
    localparam int SCORE_W   = 25;
    localparam int WIDE_W    = 27;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int QWORDS    = 4;

    localparam int RUN_STEP      = 50;
    localparam int GAP_STEP      = 20;
    localparam int BOUNDARY_GAIN = 100;
    localparam int EXACT_GAIN    = 1000;
    localparam int SWAP_COST     = 50;

    typedef logic [7:0]                t_byte;
    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    localparam t_wide SCORE_MIN = t_wide'(-100000);
    localparam t_wide SCORE_MAX = t_wide'(10000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_0   = 3'd0,
        REG_QUERY_1   = 3'd1,
        REG_QUERY_2   = 3'd2,
        REG_QUERY_3   = 3'd3,
        REG_QUERY_LEN = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [QLEN_W-1:0] mc;
        logic              last_valid;
        logic [POS_W-1:0]  last_pos;
        logic [QLEN_W-1:0] run;
        t_score            score;
    } t_match;

    function automatic t_wide sat(input t_wide v);
        if (v < SCORE_MIN) return SCORE_MIN;
        if (v > SCORE_MAX) return SCORE_MAX;
        return v;
    endfunction

    function automatic logic is_alpha(input t_byte b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_digit(input t_byte b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // space, tab through carriage return, '-', '_', '.', '/', ':'
    function automatic logic is_boundary(input t_byte b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d) || b == 8'h2d ||
               b == 8'h5f || b == 8'h2e || b == 8'h2f || b == 8'h3a;
    endfunction

endpackage

@@ sv/fss_in_if.sv @@
// Input channel of the fuzzy subsequence scorer: one text byte per word.
// Depends on fss_pkg.
interface fss_in_if;
    import fss_pkg::*;

    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ sv/fss_out_if.sv @@
// Result channel of the fuzzy subsequence scorer: one word per finished text.
// Depends on fss_pkg.
interface fss_out_if;
    import fss_pkg::*;

    logic   valid;
    logic   ready;
    logic   is_match;
    t_score score_tenths;
    logic   used_swap;
    logic   too_long;

    modport source (output valid, output is_match, output score_tenths,
                    output used_swap, output too_long, input ready);
    modport sink   (input valid, input is_match, input score_tenths,
                    input used_swap, input too_long, output ready);
endinterface

@@ sv/fuzzy_subsequence_scorer.sv @@
// Fuzzy subsequence scorer top level: query registers, two greedy matchers
// and the result register. Depends on fss_pkg, fss_in_if and fss_out_if.
//
// Usage:
//   Load the query through the write port (indexes 0..3 hold query bytes,
//   eight per word, index 4 the query length) while no text is in flight.
//   Stream the case-folded text on i_in, one byte per word, and flag the
//   final byte with end_of_text. One result word appears on o_out per text.
// Timing:
//   A byte is scored straight out of the input register; a result word
//   is loaded into the result register when its final byte is scored.
//   Throughput is one byte per cycle while the input is not stalled; the
//   per-byte update of both matchers is a single pass of compare and
//   saturating adds between two registers. During a configuration write
//   and the cycle after, ready is low while the derived swap split settles.
// Reset and stall:
//   Reset clears the query, all text state and both channels. When the
//   result is not taken, bytes that do not end a text keep flowing; a final
//   byte waits in the input register until the result register frees up.
module fuzzy_subsequence_scorer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fss_in_if.sink                         i_in,
    fss_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fss_pkg::CFG_W-1:0]      i_cfg_data
);
    import fss_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0]  r_query_word [QWORDS];
    logic [QLEN_W-1:0] r_qlen_raw;
    logic              r_cfg_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QWORDS; k++) r_query_word[k] <= '0;
            r_qlen_raw  <= '0;
            r_cfg_dirty <= 1'b0;
        end else begin
            r_cfg_dirty <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_QUERY_0:   r_query_word[0] <= i_cfg_data;
                    REG_QUERY_1:   r_query_word[1] <= i_cfg_data;
                    REG_QUERY_2:   r_query_word[2] <= i_cfg_data;
                    REG_QUERY_3:   r_query_word[3] <= i_cfg_data;
                    REG_QUERY_LEN: r_qlen_raw <= i_cfg_data[QLEN_W-1:0];
                    default: ;  // unmapped index: drop the word
                endcase
            end
        end
    end

    // Flat view of the query bytes
    t_byte w_qbyte [QUERY_MAX];
    always_comb begin
        for (int j = 0; j < QUERY_MAX; j++) begin
            w_qbyte[j] = r_query_word[j / 8][(j % 8) * 8 +: 8];
        end
    end

    // ---------------------------------------------------------------
    // Derived query properties: effective length and swap split.
    // The swapped form exists when the query is letters then digits or
    // digits then letters; the split is the size of the leading group.
    // ---------------------------------------------------------------
    logic [QLEN_W-1:0]    w_n;
    logic [QUERY_MAX-1:0] w_alpha, w_digit, w_in_rng;
    logic                 w_all_ok, w_ld_bad, w_dl_bad, w_ld_ok, w_dl_ok;
    logic                 w_swap_ok;
    logic [QLEN_W-1:0]    w_split;

    always_comb begin
        w_n = (r_qlen_raw > QLEN_W'(QUERY_MAX)) ? QLEN_W'(QUERY_MAX) : r_qlen_raw;
        for (int j = 0; j < QUERY_MAX; j++) begin
            w_alpha[j]  = is_alpha(w_qbyte[j]);
            w_digit[j]  = is_digit(w_qbyte[j]);
            w_in_rng[j] = QLEN_W'(j) < w_n;
        end
        w_all_ok = &(~w_in_rng | w_alpha | w_digit);
        w_ld_bad = 1'b0;
        w_dl_bad = 1'b0;
        for (int j = 0; j < QUERY_MAX - 1; j++) begin
            w_ld_bad = w_ld_bad | (w_in_rng[j+1] & w_digit[j] & w_alpha[j+1]);
            w_dl_bad = w_dl_bad | (w_in_rng[j+1] & w_alpha[j] & w_digit[j+1]);
        end
        w_ld_ok = (w_n != '0) && w_all_ok && !w_ld_bad && w_alpha[0] &&
                  (|(w_digit & w_in_rng));
        w_dl_ok = (w_n != '0) && w_all_ok && !w_dl_bad && w_digit[0] &&
                  (|(w_alpha & w_in_rng));
        w_swap_ok = w_ld_ok || w_dl_ok;
        if (w_ld_ok) begin
            w_split = QLEN_W'($countones(w_alpha & w_in_rng));
        end else begin
            w_split = QLEN_W'($countones(w_digit & w_in_rng));
        end
    end

    logic [QLEN_W-1:0] r_n;
    logic [QLEN_W-1:0] r_split;
    logic              r_swap_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= '0;
            r_split   <= '0;
            r_swap_ok <= 1'b0;
        end else begin
            r_n       <= w_n;
            r_split   <= w_split;
            r_swap_ok <= w_swap_ok;
        end
    end

    // ---------------------------------------------------------------
    // Input register and flow control
    // ---------------------------------------------------------------
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_eot;
    logic  r_out_valid;
    logic  w_proc;
    logic  w_accept;

    // A final byte may only be scored when the result register can take it
    assign w_proc   = r_in_valid && (!r_in_eot || !r_out_valid || o_out.ready);
    assign i_in.ready = (!r_in_valid || w_proc) && !r_cfg_dirty && !i_cfg_we;
    assign w_accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in.text_byte;
            r_in_eot  <= i_in.end_of_text;
        end
    end

    // ---------------------------------------------------------------
    // Text state
    // ---------------------------------------------------------------
    logic [BPOS_W-1:0] r_bpos;
    t_byte             r_prev;
    logic              r_ovf;
    t_match            r_m [2];

    // Score one hit of a matcher at position pos
    function automatic t_match step_hit(input t_match m, input logic [POS_W-1:0] pos,
                                        input logic bnd);
        t_match             res;
        t_wide              s;
        logic               consec;
        logic [QLEN_W-1:0]  run;
        logic [11:0]        run_pen;
        logic [POS_W-1:0]   gap;
        logic [POS_W+4:0]   gap_pen;
        res     = m;
        s       = WIDE_W'(m.score);
        consec  = m.last_valid ? (({1'b0, m.last_pos} + 1'b1) == {1'b0, pos})
                               : (pos == '0);
        run     = m.run + 1'b1;
        run_pen = 12'(run) * 12'(RUN_STEP);
        gap     = pos - m.last_pos - 1'b1;
        gap_pen = (POS_W+5)'(gap) * (POS_W+5)'(GAP_STEP);
        if (consec) begin
            res.run = run;
            s = sat(s - signed'(WIDE_W'(run_pen)));
        end else begin
            res.run = '0;
            if (m.last_valid) s = sat(s + signed'(WIDE_W'(gap_pen)));
        end
        if (bnd) s = sat(s - t_wide'(BOUNDARY_GAIN));
        s = sat(s + signed'(WIDE_W'(pos)));
        res.score      = s[SCORE_W-1:0];
        res.last_pos   = pos;
        res.last_valid = 1'b1;
        res.mc         = m.mc + 1'b1;
        return res;
    endfunction

    logic [BPOS_W-1:0] n_bpos;
    t_byte             n_prev;
    logic              n_ovf;
    t_match            n_m [2];
    logic              w_in_range, w_bnd, w_hit0, w_hit1, w_exact;
    logic [POS_W-1:0]  w_pos;
    logic [QLEN_W-1:0] w_idx1;
    logic              n_match, n_swap;
    t_wide             w_final;

    always_comb begin
        w_in_range = r_bpos < BPOS_W'(TEXT_MAX);
        w_pos      = r_bpos[POS_W-1:0];
        w_bnd      = (r_bpos == '0) || is_boundary(r_prev);

        // Rotated index into the swapped query; both terms stay below n
        w_idx1 = r_m[1].mc + r_split;
        if (w_idx1 >= r_n) w_idx1 = w_idx1 - r_n;

        w_hit0 = w_in_range && (r_m[0].mc < r_n) &&
                 (w_qbyte[r_m[0].mc[QIDX_W-1:0]] == r_in_byte);
        w_hit1 = w_in_range && r_swap_ok && (r_m[1].mc < r_n) &&
                 (w_qbyte[w_idx1[QIDX_W-1:0]] == r_in_byte);

        n_m[0] = w_hit0 ? step_hit(r_m[0], w_pos, w_bnd) : r_m[0];
        n_m[1] = w_hit1 ? step_hit(r_m[1], w_pos, w_bnd) : r_m[1];

        n_bpos = w_in_range ? r_bpos + 1'b1 : r_bpos;
        n_prev = w_in_range ? r_in_byte : r_prev;
        n_ovf  = r_ovf || !w_in_range;

        // Result of a text ending with this byte
        w_exact = (n_bpos == BPOS_W'(r_n)) && !n_ovf;
        n_match = 1'b0;
        n_swap  = 1'b0;
        w_final = '0;
        if (r_n == '0) begin
            n_match = 1'b1;
        end else if (n_m[0].mc >= r_n) begin
            n_match = 1'b1;
            w_final = WIDE_W'(n_m[0].score);
            if (w_exact) w_final = sat(w_final - t_wide'(EXACT_GAIN));
        end else if (r_swap_ok && n_m[1].mc >= r_n) begin
            n_match = 1'b1;
            n_swap  = 1'b1;
            w_final = WIDE_W'(n_m[1].score);
            if (w_exact) w_final = sat(w_final - t_wide'(EXACT_GAIN));
            w_final = sat(w_final + t_wide'(SWAP_COST));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpos <= '0;
            r_prev <= '0;
            r_ovf  <= 1'b0;
            r_m[0] <= '0;
            r_m[1] <= '0;
        end else if (w_proc) begin
            if (r_in_eot) begin
                // Text done: return to the start-of-text state
                r_bpos <= '0;
                r_prev <= '0;
                r_ovf  <= 1'b0;
                r_m[0] <= '0;
                r_m[1] <= '0;
            end else begin
                r_bpos <= n_bpos;
                r_prev <= n_prev;
                r_ovf  <= n_ovf;
                r_m[0] <= n_m[0];
                r_m[1] <= n_m[1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic   r_is_match;
    t_score r_score;
    logic   r_used_swap;
    logic   r_too_long;
    logic   w_load;

    assign w_load = w_proc && r_in_eot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_is_match  <= n_match;
            r_score     <= w_final[SCORE_W-1:0];
            r_used_swap <= n_swap;
            r_too_long  <= n_ovf;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.is_match     = r_is_match;
    assign o_out.score_tenths = r_score;
    assign o_out.used_swap    = r_used_swap;
    assign o_out.too_long     = r_too_long;

endmodule
